// File: src/gha_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the generational handle allocator
// no dependencies
package gha_pkg;

  localparam int TYPE_COUNT = 64;

  typedef enum logic [1:0] {
    MODE_BORROW = 2'd0,
    MODE_RETURN = 2'd1,
    MODE_CHECK  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_TYPE    = 3'd2,
    ST_UNALLOC = 3'd3,
    ST_POOL    = 3'd4,
    ST_STALE   = 3'd5
  } status_t;

  // register select is address bit 3 (registers at 8-byte spacing)
  localparam logic REG_POOL_ID   = 1'b0;
  localparam logic REG_TYPE_MASK = 1'b1;

  typedef struct packed {
    logic accept;
    logic pop_rd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_pop;
  } sts_t;

endpackage

// File: src/gha_if.sv
`timescale 1ns / 1ps
// request and result channel interfaces of the handle allocator
// no dependencies
interface gha_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [5:0]  type_id;
  logic [63:0] handle_in;
  modport source (output valid, mode, type_id, handle_in, input ready);
  modport sink (input valid, mode, type_id, handle_in, output ready);
endinterface

interface gha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] handle_out;
  logic        is_valid;
  logic [2:0]  status;
  modport source (output valid, handle_out, is_valid, status, input ready);
  modport sink (input valid, handle_out, is_valid, status, output ready);
endinterface

// File: src/gha_cfg.sv
`timescale 1ns / 1ps
// apb register block: pool id and type enable mask
// uses gha_pkg
module gha_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output logic [3:0]  pool_id,
  output logic [63:0] type_mask
);
  import gha_pkg::*;

  logic [3:0]  pool_id_r;
  logic [63:0] type_mask_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_id_r   <= 4'd0;
      type_mask_r <= 64'd1;
    end else if (wr_en) begin
      case (paddr[3])
        REG_POOL_ID:   pool_id_r <= pwdata[3:0];
        REG_TYPE_MASK: type_mask_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_POOL_ID:   prdata = {60'd0, pool_id_r};
      REG_TYPE_MASK: prdata = type_mask_r;
      default:       prdata = 64'd0;
    endcase
  end

  assign pool_id   = pool_id_r;
  assign type_mask = type_mask_r;

endmodule

// File: src/gha_ctrl.sv
`timescale 1ns / 1ps
// request sequencer and result valid of the handle allocator
// uses gha_pkg
module gha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  gha_pkg::sts_t sts,
  output gha_pkg::cmd_t cmd
);
  import gha_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.accept = (state_r == S_IDLE) && in_valid;
    cmd.pop_rd = (state_r == S_POP);
    cmd.finish = (state_r == S_DONE) && (!out_valid_r || out_ready);

    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = sts.need_pop ? S_POP : S_DONE;
        end
      end
      S_POP: state_nxt = S_DONE;
      S_DONE: begin
        if (cmd.finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: src/gha_dp.sv
`timescale 1ns / 1ps
// datapath: generation table, free stack, counters and result register
// uses gha_pkg
module gha_dp #(
  parameter int INDEX_COUNT      = 1024,
  parameter int GENERATION_COUNT = 65536
) (
  input  logic          clk,
  input  logic          rst_n,
  input  gha_pkg::cmd_t cmd,
  output gha_pkg::sts_t sts,
  input  logic [1:0]    in_mode,
  input  logic [5:0]    in_type_id,
  input  logic [63:0]   in_handle_in,
  input  logic [3:0]    pool_id,
  input  logic [63:0]   type_mask,
  output logic [63:0]   handle_out,
  output logic          is_valid,
  output logic [2:0]    status
);
  import gha_pkg::*;

  localparam int IW = $clog2(INDEX_COUNT);
  localparam int CW = $clog2(INDEX_COUNT + 1);
  localparam int GW = $clog2(GENERATION_COUNT);

  logic [GW-1:0] gen_mem [INDEX_COUNT];
  logic [IW-1:0] stk_mem [INDEX_COUNT];

  logic [1:0]    mode_r;
  logic [5:0]    type_r;
  logic [63:0]   handle_r;
  logic [GW-1:0] gen_rd_r;
  logic [IW-1:0] stk_rd_r;
  logic [CW-1:0] fc_r, ac_r;
  logic [63:0]   handle_out_r;
  logic          is_valid_r;
  logic [2:0]    status_r;

  logic [IW-1:0] gen_rd_addr;
  logic [31:0]   h_idx;
  logic [GW-1:0] g_new;
  status_t       chk_st, st;
  logic [63:0]   hout;
  logic          valid;
  logic          do_pop, do_fresh, do_ret, do_push;
  logic          gen_we;
  logic [IW-1:0] gen_wa;
  logic [GW-1:0] gen_wd;

  function automatic logic type_ok(input logic [5:0] t, input logic [63:0] m);
    return ({1'b0, t} < 7'(TYPE_COUNT)) && ((t == 6'd0) || m[t]);
  endfunction

  assign sts.need_pop = (in_mode == MODE_BORROW) && type_ok(in_type_id, type_mask)
                        && (fc_r != '0);

  assign gen_rd_addr = cmd.pop_rd ? stk_rd_r : in_handle_in[32 +: IW];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r   <= in_mode;
      type_r   <= in_type_id;
      handle_r <= in_handle_in;
      stk_rd_r <= stk_mem[IW'(fc_r - CW'(1))];
    end
    if (cmd.accept || cmd.pop_rd) begin
      gen_rd_r <= gen_mem[gen_rd_addr];
    end
  end

  always_comb begin
    h_idx   = handle_r[63:32];
    g_new   = (gen_rd_r == GW'(GENERATION_COUNT - 1)) ? '0 : gen_rd_r + GW'(1);
    if (h_idx >= 32'(ac_r)) begin
      chk_st = ST_UNALLOC;
    end else if (handle_r[31:28] != pool_id) begin
      chk_st = ST_POOL;
    end else if (handle_r[15:0] != 16'(gen_rd_r)) begin
      chk_st = ST_STALE;
    end else begin
      chk_st = ST_OK;
    end

    st       = ST_OK;
    hout     = 64'd0;
    valid    = 1'b0;
    do_pop   = 1'b0;
    do_fresh = 1'b0;
    do_ret   = 1'b0;
    case (mode_r)
      MODE_BORROW: begin
        if (!type_ok(type_r, type_mask)) begin
          st = ST_TYPE;
        end else if (fc_r != '0) begin
          do_pop = 1'b1;
          valid  = 1'b1;
          hout   = {32'(stk_rd_r), pool_id, 12'(type_r), 16'(gen_rd_r)};
        end else if (ac_r < CW'(INDEX_COUNT)) begin
          do_fresh = 1'b1;
          valid    = 1'b1;
          hout     = {32'(ac_r), pool_id, 12'(type_r), 16'd0};
        end else begin
          st = ST_FULL;
        end
      end
      MODE_RETURN: begin
        st = chk_st;
        if (chk_st == ST_OK) begin
          do_ret = 1'b1;
          valid  = 1'b1;
          hout   = {h_idx, pool_id, handle_r[27:16], 16'(g_new)};
        end
      end
      MODE_CHECK: begin
        st    = chk_st;
        valid = (chk_st == ST_OK);
      end
      default: ;
    endcase

    do_push = do_ret && (fc_r < CW'(INDEX_COUNT));
    gen_we  = cmd.finish && (do_fresh || do_ret);
    gen_wa  = do_fresh ? ac_r[IW-1:0] : h_idx[IW-1:0];
    gen_wd  = do_fresh ? '0 : g_new;
  end

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    if (cmd.finish && do_push) begin
      stk_mem[fc_r[IW-1:0]] <= h_idx[IW-1:0];
    end
    if (cmd.finish) begin
      handle_out_r <= hout;
      is_valid_r   <= valid;
      status_r     <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r <= '0;
      ac_r <= '0;
    end else if (cmd.finish) begin
      if (do_pop) begin
        fc_r <= fc_r - CW'(1);
      end else if (do_push) begin
        fc_r <= fc_r + CW'(1);
      end
      if (do_fresh) begin
        ac_r <= ac_r + CW'(1);
      end
    end
  end

  assign handle_out = handle_out_r;
  assign is_valid   = is_valid_r;
  assign status     = status_r;

endmodule

// File: src/generational_handle_allocator.sv
`timescale 1ns / 1ps
// top level of the generational handle allocator
// uses gha_pkg, gha_if, gha_cfg, gha_ctrl, gha_dp
//
//   channel   dir   handshake        carries
//   in_chan   in    valid/ready      mode, type_id, handle_in
//   out_chan  out   valid/ready      handle_out, is_valid, status
//   cfg       in    apb psel/penable pool_id at 0x0, type_enabled_mask at 0x8
//
// one request at a time: it is accepted in the idle state and its result is
// registered in the done state; a borrow that pops the free stack goes through
// the pop state first (stack read, then generation table read, one port each)
// synchronous reset, no clearing pass; counters start at zero
// a new request is taken while the previous result waits in the output register
// a stalled result holds the sequencer in its final state
module generational_handle_allocator #(
  parameter int INDEX_COUNT      = 1024,
  parameter int GENERATION_COUNT = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  gha_in_if.sink      in_chan,
  gha_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import gha_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [3:0]  pool_id;
  logic [63:0] type_mask;

  gha_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pool_id   (pool_id),
    .type_mask (type_mask)
  );

  gha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gha_dp #(
    .INDEX_COUNT      (INDEX_COUNT),
    .GENERATION_COUNT (GENERATION_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (in_chan.mode),
    .in_type_id   (in_chan.type_id),
    .in_handle_in (in_chan.handle_in),
    .pool_id      (pool_id),
    .type_mask    (type_mask),
    .handle_out   (out_chan.handle_out),
    .is_valid     (out_chan.is_valid),
    .status       (out_chan.status)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("request accepted while another is in flight");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.is_valid |-> out_chan.handle_out == 64'd0)
    else $error("failed result carries a nonzero handle");

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.is_valid |-> out_chan.status == ST_OK)
    else $error("valid result with error status");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.status <= ST_STALE)
    else $error("status code out of range");

endmodule
